>>> rtl/wsb_pkg.sv
// wsb_pkg: shared types, constants and the symbol encoder for the WS2812 SPI expander.
// No dependencies; every other RTL file of the block but wsb_ifs uses it.
`default_nettype none

package wsb_pkg;

   // Byte counter width: holds the longest command, which is 64 latch bytes.
   localparam int CNT_W = 7;

   // Register indexes within the configuration map (byte address = 4 * index).
   localparam logic [1:0] REG_CHANNEL_ORDER    = 2'd0;
   localparam logic [1:0] REG_WHITE_ENABLE     = 2'd1;
   localparam logic [1:0] REG_RESET_BYTE_COUNT = 2'd2;

   // Channel order codes; the unused code sends green-red-blue.
   localparam logic [1:0] ORDER_GRB = 2'd0;
   localparam logic [1:0] ORDER_RGB = 2'd1;
   localparam logic [1:0] ORDER_BGR = 2'd2;

   // Request kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_EOF   = 1'b1;

   localparam logic [CNT_W-1:0] RESET_MAX         = 7'd64;
   localparam logic [CNT_W-1:0] RESET_COUNT_INIT  = 7'd64;
   localparam logic [CNT_W-1:0] RGB_BYTES         = 7'd12;
   localparam logic [CNT_W-1:0] RGBW_BYTES        = 7'd16;

   // SPI nibble symbols: three high bits for a one, one for a zero.
   localparam logic [3:0] SYM_ONE  = 4'b1110;
   localparam logic [3:0] SYM_ZERO = 4'b1000;

   // Command queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0]       channel_order;
      logic             white_enable;
      logic [CNT_W-1:0] reset_byte_count;
   } cfg_type;

   // One classified request: either a pixel (channels already in send order)
   // or an end-of-frame with its saturated latch byte count.
   typedef struct packed {
      logic             is_eof;
      logic             preamble;
      logic             white;
      logic [CNT_W-1:0] eof_count;
      logic [3:0][7:0]  chan;      // chan[0] goes out first
   } cmd_type;

   // SPI byte idx (0..3) of a color byte: bit pairs taken MSB first,
   // the more significant bit of the pair in the high nibble.
   function automatic logic [7:0] symbol_byte(input logic [7:0] value,
                                              input logic [1:0] idx);
      logic [1:0] pair;
      unique case (idx)
         2'd0:    pair = value[7:6];
         2'd1:    pair = value[5:4];
         2'd2:    pair = value[3:2];
         default: pair = value[1:0];
      endcase
      return {pair[1] ? SYM_ONE : SYM_ZERO, pair[0] ? SYM_ONE : SYM_ZERO};
   endfunction

endpackage

`default_nettype wire

>>> rtl/wsb_ifs.sv
// wsb_ifs: valid/ready channel interfaces for pixel requests and SPI byte results.
// Depends on nothing beyond the handshake convention (accept on valid & ready).
`default_nettype none

interface wsb_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] white;

   modport source (output valid, kind, red, green, blue, white, input ready);
   modport sink   (input valid, kind, red, green, blue, white, output ready);
endinterface

interface wsb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] spi_byte;
   logic       last;

   modport source (output valid, spi_byte, last, input ready);
   modport sink   (input valid, spi_byte, last, output ready);
endinterface

`default_nettype wire

>>> rtl/wsb_front.sv
// wsb_front: accepts requests, tracks the open frame and builds queue commands.
// Depends on wsb_pkg and wsb_ifs.
`default_nettype none

module wsb_front (
   input  wire logic            clock,
   input  wire logic            reset,
   wsb_req_if.sink              req,
   input  wire wsb_pkg::cfg_type cfg,
   input  wire logic            q_full,
   output wsb_pkg::cmd_type     q_cmd,
   output logic                 q_push
);

   logic frame_open_ff;
   logic frame_open_in;
   logic accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign q_push    = accept;

   // Classify the request and put channels in send order
   always_comb begin
      q_cmd          = '0;
      q_cmd.is_eof   = (req.kind == wsb_pkg::KIND_EOF);
      q_cmd.preamble = !frame_open_ff;
      q_cmd.white    = cfg.white_enable;
      q_cmd.eof_count = (cfg.reset_byte_count > wsb_pkg::RESET_MAX) ?
                        wsb_pkg::RESET_MAX : cfg.reset_byte_count;
      q_cmd.chan[3]  = req.white;
      unique case (cfg.channel_order)
         wsb_pkg::ORDER_RGB: begin
            q_cmd.chan[0] = req.red;
            q_cmd.chan[1] = req.green;
            q_cmd.chan[2] = req.blue;
         end
         wsb_pkg::ORDER_BGR: begin
            q_cmd.chan[0] = req.blue;
            q_cmd.chan[1] = req.green;
            q_cmd.chan[2] = req.red;
         end
         default: begin
            q_cmd.chan[0] = req.green;
            q_cmd.chan[1] = req.red;
            q_cmd.chan[2] = req.blue;
         end
      endcase
   end

   // Pixel opens a frame, end-of-frame closes it
   always_comb begin
      frame_open_in = frame_open_ff;
      if (accept) begin
         frame_open_in = (req.kind == wsb_pkg::KIND_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
      end else begin
         frame_open_ff <= frame_open_in;
      end
   end

   // A pixel request always leaves the frame open
   a_pixel_opens: assert property (@(posedge clock) disable iff (reset)
      (accept && req.kind == wsb_pkg::KIND_PIXEL) |=> frame_open_ff)
      else $error("frame not open after pixel request");

endmodule

`default_nettype wire

>>> rtl/wsb_fifo.sv
// wsb_fifo: short command queue between the front and back end.
// Depends on wsb_pkg for the command type and depth.
`default_nettype none

module wsb_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire wsb_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output wsb_pkg::cmd_type      head_cmd,
   output logic                  head_valid
);

   localparam int PTR_W = (wsb_pkg::QUEUE_DEPTH > 1) ? $clog2(wsb_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(wsb_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(wsb_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(wsb_pkg::QUEUE_DEPTH - 1);

   wsb_pkg::cmd_type mem_ff [wsb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == DEPTH_C);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_P) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_P) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("command queue underflow");

endmodule

`default_nettype wire

>>> rtl/wsb_back.sv
// wsb_back: shifts the queue head out as registered SPI bytes, one per cycle unless stalled.
// Depends on wsb_pkg and wsb_ifs.
`default_nettype none

module wsb_back #(
   parameter int PREAMBLE_BYTES = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire wsb_pkg::cmd_type head_cmd,
   input  wire logic             head_valid,
   output logic                  pop,
   wsb_rsp_if.source             rsp
);

   localparam logic [wsb_pkg::CNT_W-1:0] PRE_LEN = wsb_pkg::CNT_W'(PREAMBLE_BYTES);

   logic [wsb_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      valid_ff, valid_in;
   logic [7:0]                byte_ff, byte_in;
   logic                      last_ff, last_in;

   logic [wsb_pkg::CNT_W-1:0] total;
   logic [wsb_pkg::CNT_W-1:0] pre_len;
   logic [wsb_pkg::CNT_W-1:0] data_idx;
   logic                      in_pre;
   logic                      slot_free;
   logic                      is_last;
   logic [7:0]                next_byte;

   // Length of the head command
   always_comb begin
      pre_len = head_cmd.preamble ? PRE_LEN : '0;
      if (head_cmd.is_eof) begin
         total = head_cmd.eof_count;
      end else begin
         total = pre_len + (head_cmd.white ? wsb_pkg::RGBW_BYTES : wsb_pkg::RGB_BYTES);
      end
   end

   // Byte at the current position
   assign in_pre   = (cnt_ff < pre_len);
   assign data_idx = cnt_ff - pre_len;
   assign is_last  = (cnt_ff == total - 1'b1);

   always_comb begin
      if (head_cmd.is_eof || in_pre) begin
         next_byte = 8'h00;
      end else begin
         next_byte = wsb_pkg::symbol_byte(head_cmd.chan[data_idx[3:2]], data_idx[1:0]);
      end
   end

   assign slot_free = !valid_ff || rsp.ready;

   // Sequencer: empty commands retire without output
   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp.ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      priority if (head_valid && total == '0) begin
         pop = 1'b1;
      end else if (head_valid && slot_free) begin
         valid_in = 1'b1;
         byte_in  = next_byte;
         last_in  = is_last;
         if (is_last) begin
            cnt_in = '0;
            pop    = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else begin
         // nothing queued or output stalled: hold position
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.spi_byte = byte_ff;
   assign rsp.last     = last_ff;

   // Mid-command the head must still be present
   a_head_held: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> head_valid)
      else $error("queue head lost in the middle of a command");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (cnt_ff < total || total == '0))
      else $error("byte counter past command length");

endmodule

`default_nettype wire

>>> rtl/ws2812_spi_bit_expander.sv
// WS2812 SPI bit expander. Each pixel request produces 12 SPI bytes (16 with white
// enabled), preceded by PREAMBLE_BYTES zero bytes on the first pixel of a frame;
// an end-of-frame request produces reset_byte_count zero bytes (capped at 64), and
// last is set on the final byte of every command. The back-end serializer emits one
// byte per cycle while the result channel is not stalled; an end-of-frame with a
// zero count retires from the queue with no output. A two-entry command queue lets
// the next request be accepted while the current one is still being shifted out.
// Configuration is by APB at byte addresses 0 (channel_order), 4 (white_enable),
// 8 (reset_byte_count).
`default_nettype none

module ws2812_spi_bit_expander #(
   parameter int PREAMBLE_BYTES = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   wsb_req_if.sink          req_ch,
   wsb_rsp_if.source        rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   wsb_pkg::cfg_type cfg_ff, cfg_in;
   wsb_pkg::cmd_type push_cmd, head_cmd;
   logic             push, pop, q_full, head_valid;
   logic             csr_write;
   logic [1:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx)
            wsb_pkg::REG_CHANNEL_ORDER:    cfg_in.channel_order    = csr_pwdata[1:0];
            wsb_pkg::REG_WHITE_ENABLE:     cfg_in.white_enable     = csr_pwdata[0];
            wsb_pkg::REG_RESET_BYTE_COUNT:
               cfg_in.reset_byte_count = csr_pwdata[wsb_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_order    <= wsb_pkg::ORDER_GRB;
         cfg_ff.white_enable     <= 1'b0;
         cfg_ff.reset_byte_count <= wsb_pkg::RESET_COUNT_INIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads
   always_comb begin
      unique case (reg_idx)
         wsb_pkg::REG_CHANNEL_ORDER:    csr_prdata = {30'd0, cfg_ff.channel_order};
         wsb_pkg::REG_WHITE_ENABLE:     csr_prdata = {31'd0, cfg_ff.white_enable};
         wsb_pkg::REG_RESET_BYTE_COUNT:
            csr_prdata = {{(32-wsb_pkg::CNT_W){1'b0}}, cfg_ff.reset_byte_count};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   wsb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .q_cmd  (push_cmd),
      .q_push (push)
   );

   wsb_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid)
   );

   wsb_back #(
      .PREAMBLE_BYTES (PREAMBLE_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule

`default_nettype wire
